>>> rtl/core/sbw_pkg.sv
// shared types and constants of the scaled blit walker
`timescale 1ns / 1ps

package sbw_pkg;

    // field widths
    localparam int SIZE_W  = 13;
    localparam int TPOS_W  = 12;
    localparam int DIDX_W  = 20;
    localparam int SIDX_W  = 24;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    // largest destination rectangle side
    localparam logic [SIZE_W-1:0] DST_MAX = 13'd4096;

    // register indexes on the configuration port
    localparam logic [2:0] REG_TEX_WIDTH  = 3'd0;
    localparam logic [2:0] REG_TEX_HEIGHT = 3'd1;
    localparam logic [2:0] REG_DST_LEFT   = 3'd2;
    localparam logic [2:0] REG_DST_TOP    = 3'd3;
    localparam logic [2:0] REG_DST_WIDTH  = 3'd4;
    localparam logic [2:0] REG_DST_HEIGHT = 3'd5;

    // saturated sizes, placement and per-pixel texel steps
    typedef struct packed {
        logic              busy;
        logic [SIZE_W-1:0] tex_w;
        logic [SIZE_W-1:0] tex_h;
        logic [SIZE_W-1:0] dst_w;
        logic [SIZE_W-1:0] dst_h;
        logic [SIZE_W-1:0] left;
        logic [SIZE_W-1:0] top;
        logic [SIZE_W-1:0] col_q;
        logic [SIZE_W-1:0] col_r;
        logic [SIZE_W-1:0] row_q;
        logic [SIZE_W-1:0] row_r;
    } sbw_cfg_t;

    // walk position handed from the walker to address generation
    typedef struct packed {
        logic              valid;
        logic              row_load;
        logic              done;
        logic [SIZE_W-1:0] col;
        logic [SIZE_W-1:0] row;
        logic [TPOS_W-1:0] tcol;
        logic [TPOS_W-1:0] trow;
    } sbw_stage_t;

    // finished result ahead of the output register
    typedef struct packed {
        logic              valid;
        logic              visible;
        logic              done;
        logic [DIDX_W-1:0] dst_index;
        logic [SIDX_W-1:0] src_index;
    } sbw_res_t;

endpackage

>>> rtl/core/scaled_clipped_blit_walker_core.sv
// A result passes the stage register, the address register and the output register.
// Throughput: one position per clock unless busy; only a stalled output holds the pipeline.
// After reset and after every register write the texel steps are recomputed by
// two 13-bit shift-subtract dividers: input is stalled while they run.
// Reset clears the walk, so an advance before the first restart gives nothing.
`timescale 1ns / 1ps

module scaled_clipped_blit_walker_core #(
    parameter int WIN_WIDTH  = 1024,
    parameter int WIN_HEIGHT = 1024,
    parameter int TEX_MAX    = 4096
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          restart,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          visible,
    output logic [sbw_pkg::DIDX_W-1:0]    dst_index,
    output logic [sbw_pkg::SIDX_W-1:0]    src_index,
    output logic                          done_res,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sbw_pkg::ADDR_W-1:0]    paddr,
    input  logic [sbw_pkg::DATA_W-1:0]    pwdata,
    output logic [sbw_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);

    sbw_pkg::sbw_cfg_t   cfg;
    sbw_pkg::sbw_stage_t stage;
    sbw_pkg::sbw_res_t   res;

    logic                       en, fire;
    logic                       out_valid_reg, vis_reg, done_reg;
    logic [sbw_pkg::DIDX_W-1:0] dst_reg;
    logic [sbw_pkg::SIDX_W-1:0] src_reg;

    // pipeline advances unless a result is held by the consumer
    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = cfg.busy || !en;
    assign fire     = in_valid && !in_stall;

    sbw_cfg #(
        .TEX_MAX (TEX_MAX)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sbw_step u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .fire    (fire),
        .restart (restart),
        .cfg     (cfg),
        .stage   (stage)
    );

    sbw_addr #(
        .WIN_WIDTH  (WIN_WIDTH),
        .WIN_HEIGHT (WIN_HEIGHT)
    ) u_addr (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .stage (stage),
        .cfg   (cfg),
        .res   (res)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= res.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vis_reg  <= res.visible;
            done_reg <= res.done;
            dst_reg  <= res.dst_index;
            src_reg  <= res.src_index;
        end
    end

    assign out_valid = out_valid_reg;
    assign visible   = vis_reg;
    assign done_res  = done_reg;
    assign dst_index = dst_reg;
    assign src_index = src_reg;

    // no transaction is taken while the texel steps are recomputed
    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        cfg.busy |-> in_stall)
        else $error("input accepted during step recompute");

endmodule

>>> rtl/core/sbw_cfg.sv
// configuration registers, size saturation and texel step dividers
`timescale 1ns / 1ps

module sbw_cfg #(
    parameter int TEX_MAX = 4096
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sbw_pkg::ADDR_W-1:0]  paddr,
    input  logic [sbw_pkg::DATA_W-1:0]  pwdata,
    output logic [sbw_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output sbw_pkg::sbw_cfg_t           cfg
);

    localparam int SW = sbw_pkg::SIZE_W;
    localparam logic [SW-1:0] TexMax = SW'(TEX_MAX);
    localparam logic [3:0] LastStep = 4'(SW - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOAD = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;

    function automatic logic [SW-1:0] clamp_size(logic [SW-1:0] v, logic [SW-1:0] hi);
        logic [SW-1:0] r;
        begin
            if (v == '0)
                r = SW'(1);
            else if (v > hi)
                r = hi;
            else
                r = v;
            return r;
        end
    endfunction

    logic          wr;
    logic [2:0]    idx;
    logic [SW-1:0] tex_w_reg, tex_h_reg, left_reg, top_reg, dst_w_reg, dst_h_reg;
    logic [SW-1:0] tw_c_reg, th_c_reg, dw_c_reg, dh_c_reg;
    logic [SW-1:0] tw_c, th_c, dw_c, dh_c;
    logic [1:0]    state_reg, state_next;
    logic [3:0]    cnt_reg, cnt_next;
    logic [SW-1:0] hq_reg, hq_next, hr_reg, hr_next;
    logic [SW-1:0] vq_reg, vq_next, vr_reg, vr_next;
    logic [SW:0]   h_sh, v_sh;
    logic          h_ge, v_ge;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign idx    = paddr[4:2];

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tex_w_reg <= SW'(1);
            tex_h_reg <= SW'(1);
            left_reg  <= '0;
            top_reg   <= '0;
            dst_w_reg <= SW'(1);
            dst_h_reg <= SW'(1);
        end
        else if (wr)
        begin
            case (idx)
                sbw_pkg::REG_TEX_WIDTH:  tex_w_reg <= pwdata[SW-1:0];
                sbw_pkg::REG_TEX_HEIGHT: tex_h_reg <= pwdata[SW-1:0];
                sbw_pkg::REG_DST_LEFT:   left_reg  <= pwdata[SW-1:0];
                sbw_pkg::REG_DST_TOP:    top_reg   <= pwdata[SW-1:0];
                sbw_pkg::REG_DST_WIDTH:  dst_w_reg <= pwdata[SW-1:0];
                sbw_pkg::REG_DST_HEIGHT: dst_h_reg <= pwdata[SW-1:0];
                default: ;
            endcase
        end
    end

    // register reads
    always_comb
    begin
        case (idx)
            sbw_pkg::REG_TEX_WIDTH:  prdata = sbw_pkg::DATA_W'(tex_w_reg);
            sbw_pkg::REG_TEX_HEIGHT: prdata = sbw_pkg::DATA_W'(tex_h_reg);
            sbw_pkg::REG_DST_LEFT:   prdata = sbw_pkg::DATA_W'(left_reg);
            sbw_pkg::REG_DST_TOP:    prdata = sbw_pkg::DATA_W'(top_reg);
            sbw_pkg::REG_DST_WIDTH:  prdata = sbw_pkg::DATA_W'(dst_w_reg);
            sbw_pkg::REG_DST_HEIGHT: prdata = sbw_pkg::DATA_W'(dst_h_reg);
            default:                 prdata = '0;
        endcase
    end

    // saturated sizes
    assign tw_c = clamp_size(tex_w_reg, TexMax);
    assign th_c = clamp_size(tex_h_reg, TexMax);
    assign dw_c = clamp_size(dst_w_reg, sbw_pkg::DST_MAX);
    assign dh_c = clamp_size(dst_h_reg, sbw_pkg::DST_MAX);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tw_c_reg <= SW'(1);
            th_c_reg <= SW'(1);
            dw_c_reg <= SW'(1);
            dh_c_reg <= SW'(1);
        end
        else
        begin
            tw_c_reg <= tw_c;
            th_c_reg <= th_c;
            dw_c_reg <= dw_c;
            dh_c_reg <= dh_c;
        end
    end

    // restoring dividers, one quotient bit per cycle
    assign h_sh = {hr_reg, hq_reg[SW-1]};
    assign v_sh = {vr_reg, vq_reg[SW-1]};
    assign h_ge = h_sh >= {1'b0, dw_c_reg};
    assign v_ge = v_sh >= {1'b0, dh_c_reg};

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        hq_next    = hq_reg;
        hr_next    = hr_reg;
        vq_next    = vq_reg;
        vr_next    = vr_reg;
        case (state_reg)
            ST_LOAD:
            begin
                hq_next    = tw_c;
                hr_next    = '0;
                vq_next    = th_c;
                vr_next    = '0;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                hq_next  = {hq_reg[SW-2:0], h_ge};
                hr_next  = h_ge ? SW'(h_sh - {1'b0, dw_c_reg}) : h_sh[SW-1:0];
                vq_next  = {vq_reg[SW-2:0], v_ge};
                vr_next  = v_ge ? SW'(v_sh - {1'b0, dh_c_reg}) : v_sh[SW-1:0];
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == LastStep)
                    state_next = ST_IDLE;
            end
            ST_IDLE: ;
            default: state_next = ST_LOAD;
        endcase
        // any write recomputes the steps
        if (wr)
            state_next = ST_LOAD;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hq_reg <= hq_next;
        hr_reg <= hr_next;
        vq_reg <= vq_next;
        vr_reg <= vr_next;
    end

    // configuration seen by the datapath
    always_comb
    begin
        cfg.busy  = (state_reg != ST_IDLE);
        cfg.tex_w = tw_c_reg;
        cfg.tex_h = th_c_reg;
        cfg.dst_w = dw_c_reg;
        cfg.dst_h = dh_c_reg;
        cfg.left  = left_reg;
        cfg.top   = top_reg;
        cfg.col_q = hq_reg;
        cfg.col_r = hr_reg;
        cfg.row_q = vq_reg;
        cfg.row_r = vr_reg;
    end

    // a write always triggers a recompute
    a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        wr |=> cfg.busy)
        else $error("step recompute not started after a register write");

endmodule

>>> rtl/core/sbw_step.sv
// raster walker: position counters and texel accumulators
`timescale 1ns / 1ps

module sbw_step (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                fire,
    input  logic                restart,
    input  sbw_pkg::sbw_cfg_t   cfg,
    output sbw_pkg::sbw_stage_t stage
);

    localparam int SW = sbw_pkg::SIZE_W;
    localparam int TW = sbw_pkg::TPOS_W;

    // one texel step: quotient plus a carry out of the remainder
    function automatic logic [TW+SW-1:0] advance(
        logic [TW-1:0] pos, logic [SW-1:0] rem,
        logic [SW-1:0] q, logic [SW-1:0] r, logic [SW-1:0] d);
        logic [SW:0]   nr;
        logic [TW-1:0] np;
        begin
            nr = {1'b0, rem} + {1'b0, r};
            np = pos + q[TW-1:0];
            if (nr >= {1'b0, d})
            begin
                nr = nr - {1'b0, d};
                np = np + TW'(1);
            end
            return {np, nr[SW-1:0]};
        end
    endfunction

    logic [SW-1:0] col_reg, col_next, row_reg, row_next;
    logic [TW-1:0] tcol_reg, tcol_next, trow_reg, trow_next;
    logic [SW-1:0] crem_reg, crem_next, rrem_reg, rrem_next;
    logic          active_reg, active_next;
    logic          emit, load, done;
    logic          row_end;
    logic [SW:0]   col_p1;
    sbw_pkg::sbw_stage_t stage_reg;

    assign col_p1  = {1'b0, col_reg} + {{SW{1'b0}}, 1'b1};
    assign row_end = col_p1 >= {1'b0, cfg.dst_w};

    // next walk position
    always_comb
    begin
        col_next    = col_reg;
        row_next    = row_reg;
        tcol_next   = tcol_reg;
        trow_next   = trow_reg;
        crem_next   = crem_reg;
        rrem_next   = rrem_reg;
        active_next = active_reg;
        emit        = 1'b0;
        load        = 1'b0;
        if (fire)
        begin
            if (restart)
            begin
                col_next    = '0;
                row_next    = '0;
                tcol_next   = '0;
                trow_next   = '0;
                crem_next   = '0;
                rrem_next   = '0;
                active_next = 1'b1;
                emit        = 1'b1;
                load        = 1'b1;
            end
            else if (active_reg)
            begin
                emit = 1'b1;
                if (row_end)
                begin
                    col_next  = '0;
                    tcol_next = '0;
                    crem_next = '0;
                    row_next  = row_reg + SW'(1);
                    {trow_next, rrem_next} = advance(trow_reg, rrem_reg,
                        cfg.row_q, cfg.row_r, cfg.dst_h);
                    load = 1'b1;
                end
                else
                begin
                    col_next = col_p1[SW-1:0];
                    {tcol_next, crem_next} = advance(tcol_reg, crem_reg,
                        cfg.col_q, cfg.col_r, cfg.dst_w);
                end
            end
        end
        done = (({1'b0, col_next} + (SW+1)'(1)) >= {1'b0, cfg.dst_w})
            && (({1'b0, row_next} + (SW+1)'(1)) >= {1'b0, cfg.dst_h});
        if (emit && done)
            active_next = 1'b0;
    end

    // walk state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg    <= '0;
            row_reg    <= '0;
            tcol_reg   <= '0;
            trow_reg   <= '0;
            crem_reg   <= '0;
            rrem_reg   <= '0;
            active_reg <= 1'b0;
        end
        else
        begin
            col_reg    <= col_next;
            row_reg    <= row_next;
            tcol_reg   <= tcol_next;
            trow_reg   <= trow_next;
            crem_reg   <= crem_next;
            rrem_reg   <= rrem_next;
            active_reg <= active_next;
        end
    end

    // stage register toward address generation
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_reg <= '0;
        else if (en)
        begin
            stage_reg.valid    <= emit;
            stage_reg.row_load <= load;
            stage_reg.done     <= done;
            stage_reg.col      <= col_next;
            stage_reg.row      <= row_next;
            stage_reg.tcol     <= tcol_next;
            stage_reg.trow     <= trow_next;
        end
    end

    assign stage = stage_reg;

    // an advance with no walk running makes no result
    a_idle_advance: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !restart && !active_reg |=> !stage_reg.valid)
        else $error("result made by an advance while idle");

    // the last position ends the walk
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        stage_reg.valid && stage_reg.done |-> !active_reg)
        else $error("walk still active after its last position");

endmodule

>>> rtl/core/sbw_addr.sv
// framebuffer and texel address generation with window clipping
`timescale 1ns / 1ps

module sbw_addr #(
    parameter int WIN_WIDTH  = 1024,
    parameter int WIN_HEIGHT = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  sbw_pkg::sbw_stage_t stage,
    input  sbw_pkg::sbw_cfg_t   cfg,
    output sbw_pkg::sbw_res_t   res
);

    localparam int SW = sbw_pkg::SIZE_W;
    localparam int TW = sbw_pkg::TPOS_W;
    localparam int DW = sbw_pkg::DIDX_W;
    localparam int XW = sbw_pkg::SIDX_W;
    localparam logic [SW-1:0] WinW = SW'(WIN_WIDTH);
    localparam logic [SW-1:0] WinH = SW'(WIN_HEIGHT);

    logic [SW:0]      x, y;
    logic             vis;
    logic [2*SW-1:0]  yw_full;
    logic [TW+SW-1:0] base_full;

    logic             valid_reg, vis_reg, done_reg;
    logic [SW-1:0]    x_reg;
    logic [DW-1:0]    yw_reg;
    logic [TW-1:0]    tcol_reg;
    logic [XW-1:0]    base_reg;

    // window position and clip test
    assign x   = {cfg.left[SW-1], cfg.left} + {1'b0, stage.col};
    assign y   = {cfg.top[SW-1], cfg.top} + {1'b0, stage.row};
    assign vis = !x[SW] && (x[SW-1:0] < WinW) && !y[SW] && (y[SW-1:0] < WinH);

    // row offset in the framebuffer and texel row base
    assign yw_full   = y[SW-1:0] * WinW;
    assign base_full = stage.trow * cfg.tex_w;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= stage.valid;
            done_reg  <= stage.done;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vis_reg  <= vis;
            x_reg    <= x[SW-1:0];
            yw_reg   <= yw_full[DW-1:0];
            tcol_reg <= stage.tcol;
        end
    end

    // texel row base changes only at the start of a row
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            base_reg <= '0;
        else if (en && stage.valid && stage.row_load)
            base_reg <= base_full[XW-1:0];
    end

    // final indexes
    always_comb
    begin
        res.valid     = valid_reg;
        res.visible   = vis_reg;
        res.done      = done_reg;
        res.dst_index = vis_reg ? (yw_reg + DW'(x_reg)) : '0;
        res.src_index = base_reg + XW'(tcol_reg);
    end

endmodule
